FILE: rtl/banked_memory_map_with_protection_assert.svh
// ----------------------------------------------------------------------------
// Banked memory map with protection: assertion macros
// Shared property forms used by the RTL assertions.
// ----------------------------------------------------------------------------
`ifndef BANKED_MEMORY_MAP_WITH_PROTECTION_ASSERT_SVH
`define BANKED_MEMORY_MAP_WITH_PROTECTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bmm_pkg.sv
// ----------------------------------------------------------------------------
// Banked memory map with protection: package
// Types, codes and constants shared by the front and back parts.
// ----------------------------------------------------------------------------
package bmm_pkg;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RT_MEM_RD = 3'd0,
      RT_MEM_WR = 3'd1,
      RT_ROM_WR = 3'd2,
      RT_IO_RD  = 3'd3,
      RT_IO_WR  = 3'd4,
      RT_REG_WR = 3'd5,
      RT_DBG_RD = 3'd6,
      RT_TICK   = 3'd7
   } route_type;

   localparam logic [1:0] CSR_PROTECTED = 2'd0;
   localparam logic [1:0] CSR_IO_PAGE   = 2'd1;
   localparam logic [1:0] CSR_WD_LIMIT  = 2'd2;

   localparam int CSR_WIDTH = 17;

   localparam logic [7:0]  IO_PAGE_RESET  = 8'hFE;
   localparam logic [16:0] WD_LIMIT_RESET = 17'h10000;
   localparam logic [16:0] WD_MAX         = 17'h1FFFF;

   localparam logic [15:0] VECTOR_BASE = 16'hFFF0;
   localparam logic [15:0] HIGH_BASE   = 16'hE000;
   localparam logic [7:0]  BANK_FIRST  = 8'h78;
   localparam logic [7:0]  BANK_LAST   = 8'h7B;
   localparam logic [7:0]  ENABLE_FIRST = 8'h7C;
   localparam logic [7:0]  ENABLE_LAST  = 8'h7F;
   localparam logic [7:0]  MMU_OFFSET  = 8'hFF;
   localparam logic [7:0]  VECTOR_MMU  = 8'h02;
   localparam logic [7:0]  DEBUG_BYTE  = 8'hFF;
   localparam logic [5:0]  ROM_PAGES   = 6'd32;

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   typedef struct packed {
      op_type      op;
      logic [15:0] addr;
      logic [7:0]  val;
      logic        dbg;
      logic        off_bank;
      logic        off_enable;
      logic        off_mmu;
      logic        vector;
      logic        low_area;
   } cls_type;

   typedef struct packed {
      route_type   route;
      logic [19:0] phys;
      logic [7:0]  ioff;
      logic [7:0]  dout;
      logic        nmi;
      logic        kernel;
   } rsp_type;

endpackage

FILE: rtl/bmm_front.sv
// ----------------------------------------------------------------------------
// Banked memory map with protection: front part
// Accepts items, pre-decodes address and offset classes, and holds them in a
// two-entry queue for the back part.
// ----------------------------------------------------------------------------
module bmm_front import bmm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_cpu_address,
   input  logic [7:0]  req_write_value,
   input  logic        req_debug_access,
   output logic        head_valid,
   output cls_type     head,
   input  logic        head_take
);

   cls_type    q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept;
   logic       take;
   cls_type    cls;
   logic [7:0] off;

   assign off = req_cpu_address[7:0];

   always_comb begin
      cls.op         = op_type'(req_operation);
      cls.addr       = req_cpu_address;
      cls.val        = req_write_value;
      cls.dbg        = req_debug_access;
      cls.off_bank   = (off >= BANK_FIRST) && (off <= BANK_LAST);
      cls.off_enable = (off >= ENABLE_FIRST) && (off <= ENABLE_LAST);
      cls.off_mmu    = (off == MMU_OFFSET);
      cls.vector     = (req_cpu_address >= VECTOR_BASE);
      cls.low_area   = (req_cpu_address < HIGH_BASE);
   end

   assign full       = reset || (cnt_ff == QUEUE_DEPTH);
   assign accept     = push && !full;
   assign head_valid = (cnt_ff != 2'd0);
   assign take       = head_take && head_valid;
   assign head       = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: rtl/bmm_back.sv
// ----------------------------------------------------------------------------
// Banked memory map with protection: back part
// Holds the map, mode and watchdog state, carries out one classified item per
// cycle while its two-entry output queue has room and puts its result there.
// ----------------------------------------------------------------------------
`include "banked_memory_map_with_protection_assert.svh"

module bmm_back import bmm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata,
   input  logic                 head_valid,
   input  cls_type              head,
   output logic                 head_take,
   output logic                 empty,
   input  logic                 pop,
   output rsp_type              rsp_head
);

   logic        protected_ff;
   logic [7:0]  io_page_ff;
   logic [16:0] wd_limit_ff;

   logic [5:0]  bank_ff [4];
   logic        banking_on_ff, banking_on_in;
   logic [7:0]  mmu_ff, mmu_in;
   logic        sup_ff, sup_in;
   logic [16:0] wd_cnt_ff, wd_cnt_in;
   logic        bank_we;

   rsp_type     out_mem_ff [2];
   logic        out_wr_ff, out_rd_ff;
   logic [1:0]  out_cnt_ff, out_cnt_in;
   logic        exec;
   logic        out_take;

   rsp_type     res;
   logic        io_hit;
   logic [7:0]  mmu_eff;
   logic [7:0]  reg_sel;
   logic [3:0]  region;
   logic [5:0]  page;
   logic [16:0] wd_inc;

   assign exec      = head_valid && (out_cnt_ff != QUEUE_DEPTH);
   assign head_take = exec;
   assign empty     = reset || (out_cnt_ff == 2'd0);
   assign out_take  = pop && !empty;
   assign rsp_head  = out_mem_ff[out_rd_ff];

   always_comb begin
      io_hit  = (head.addr[15:8] == io_page_ff) && sup_ff;
      mmu_eff = (head.op == OP_READ && !io_hit && protected_ff && head.vector) ?
                VECTOR_MMU : mmu_ff;
      reg_sel = head.low_area ? {1'b0, mmu_eff[7:1]} : mmu_eff;
      region  = {reg_sel[0], reg_sel[2], reg_sel[4], reg_sel[6]};
      page    = bank_ff[head.addr[15:14]];
      wd_inc  = wd_cnt_ff + 17'd1;

      banking_on_in = banking_on_ff;
      mmu_in        = mmu_ff;
      sup_in        = sup_ff;
      wd_cnt_in     = wd_cnt_ff;
      bank_we       = 1'b0;

      res.route = RT_TICK;
      res.phys  = 20'd0;
      res.ioff  = 8'd0;
      res.dout  = 8'd0;
      res.nmi   = 1'b0;

      case (head.op)
         OP_TICK: begin
            if (protected_ff) begin
               if (!sup_ff) begin
                  if (wd_cnt_ff < WD_MAX) begin
                     wd_cnt_in = wd_inc;
                     res.nmi   = (wd_inc == wd_limit_ff);
                  end
               end else begin
                  wd_cnt_in = 17'd0;
               end
            end
         end
         OP_READ: begin
            if (io_hit) begin
               res.ioff = head.addr[7:0];
               if (head.dbg) begin
                  res.route = RT_DBG_RD;
                  res.dout  = DEBUG_BYTE;
               end else begin
                  res.route = RT_IO_RD;
               end
            end else begin
               res.route = RT_MEM_RD;
               if (protected_ff) begin
                  if (head.vector) begin
                     mmu_in = VECTOR_MMU;
                     sup_in = 1'b1;
                  end
                  res.phys = {region, head.addr};
               end else if (banking_on_ff) begin
                  res.phys = {page, head.addr[13:0]};
               end else begin
                  res.phys = {6'd0, head.addr[13:0]};
               end
            end
         end
         OP_WRITE: begin
            res.dout = head.val;
            if (io_hit) begin
               res.ioff  = head.addr[7:0];
               res.route = RT_IO_WR;
               if (!protected_ff && head.off_bank) begin
                  bank_we   = 1'b1;
                  res.route = RT_REG_WR;
               end else if (!protected_ff && head.off_enable) begin
                  banking_on_in = head.val[0];
                  res.route     = RT_REG_WR;
               end else if (protected_ff && head.off_mmu) begin
                  mmu_in    = head.val;
                  sup_in    = 1'b0;
                  res.route = RT_REG_WR;
               end
            end else if (protected_ff) begin
               res.phys  = {region, head.addr};
               res.route = region[3] ? RT_MEM_WR : RT_ROM_WR;
            end else if (banking_on_ff) begin
               res.phys  = {page, head.addr[13:0]};
               res.route = (page >= ROM_PAGES) ? RT_MEM_WR : RT_ROM_WR;
            end else begin
               res.phys  = {6'd0, head.addr[13:0]};
               res.route = RT_ROM_WR;
            end
         end
         default: begin
            res.route = RT_TICK;
         end
      endcase

      res.kernel = sup_in;
      out_cnt_in = out_cnt_ff + {1'b0, exec} - {1'b0, out_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protected_ff <= 1'b0;
         io_page_ff   <= IO_PAGE_RESET;
         wd_limit_ff  <= WD_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PROTECTED: protected_ff <= csr_wdata[0];
            CSR_IO_PAGE:   io_page_ff   <= csr_wdata[7:0];
            CSR_WD_LIMIT:  wd_limit_ff  <= csr_wdata;
            default:       protected_ff <= protected_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            bank_ff[i] <= 6'd0;
         end
         banking_on_ff <= 1'b0;
         mmu_ff        <= 8'd0;
         sup_ff        <= 1'b1;
         wd_cnt_ff     <= 17'd0;
      end else if (exec) begin
         if (bank_we) begin
            bank_ff[head.addr[1:0]] <= head.val[5:0];
         end
         banking_on_ff <= banking_on_in;
         mmu_ff        <= mmu_in;
         sup_ff        <= sup_in;
         wd_cnt_ff     <= wd_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         if (exec) begin
            out_wr_ff <= out_wr_ff + 1'b1;
         end
         if (out_take) begin
            out_rd_ff <= out_rd_ff + 1'b1;
         end
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         out_mem_ff[out_wr_ff] <= res;
      end
   end

   `BMM_ASSERT_IMP(a_nmi_on_tick, clock, reset, exec && res.nmi,
      res.route == RT_TICK, "watchdog pulse on a non-tick item")
   `BMM_ASSERT_IMP(a_phys_zero, clock, reset,
      exec && (res.route == RT_IO_RD || res.route == RT_IO_WR ||
      res.route == RT_REG_WR || res.route == RT_DBG_RD || res.route == RT_TICK),
      res.phys == 20'd0, "physical address set on a non-memory route")
   `BMM_ASSERT_NXT(a_wd_clear, clock, reset,
      exec && head.op == OP_TICK && protected_ff && sup_ff,
      wd_cnt_ff == 17'd0, "watchdog not cleared by a kernel-mode tick")
   `BMM_ASSERT_NXT(a_mmu_user, clock, reset,
      exec && res.route == RT_REG_WR && protected_ff,
      !sup_ff && mmu_ff == $past(head.val), "MMU write did not enter user mode")

endmodule

FILE: rtl/banked_memory_map_with_protection.sv
// ----------------------------------------------------------------------------
// Banked memory map with protection: top level
// Translates CPU reads, writes and watchdog ticks into routed results.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while full is low and returns one
// result per item, in order. An accepted item is decoded and queued by the
// front part, carried out by the back part once its output queue has room,
// and then waits in that queue until it is popped. The rate of one item per
// cycle is set by the back part, which updates the bank, MMU, mode and
// watchdog state once per item; two-entry queues on both sides of it absorb
// stalls, and only results left waiting slow the input. Full and empty stay
// high while reset is asserted.
module banked_memory_map_with_protection import bmm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           req_operation,
   input  logic [15:0]          req_cpu_address,
   input  logic [7:0]           req_write_value,
   input  logic                 req_debug_access,
   output logic                 empty,
   input  logic                 pop,
   output logic [2:0]           rsp_route,
   output logic [19:0]          rsp_physical_address,
   output logic [7:0]           rsp_io_offset,
   output logic [7:0]           rsp_data_out,
   output logic                 rsp_nmi_pulse,
   output logic                 rsp_kernel_mode
);

   logic    head_valid;
   logic    head_take;
   cls_type head;
   rsp_type rsp_head;

   bmm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_operation    (req_operation),
      .req_cpu_address  (req_cpu_address),
      .req_write_value  (req_write_value),
      .req_debug_access (req_debug_access),
      .head_valid       (head_valid),
      .head             (head),
      .head_take        (head_take)
   );

   bmm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take),
      .empty      (empty),
      .pop        (pop),
      .rsp_head   (rsp_head)
   );

   assign rsp_route            = rsp_head.route;
   assign rsp_physical_address = rsp_head.phys;
   assign rsp_io_offset        = rsp_head.ioff;
   assign rsp_data_out         = rsp_head.dout;
   assign rsp_nmi_pulse        = rsp_head.nmi;
   assign rsp_kernel_mode      = rsp_head.kernel;

endmodule

FILE: dv/banked_memory_map_with_protection_test.sv
// ----------------------------------------------------------------------------
// Banked memory map with protection: testbench
// Drives reads, writes and watchdog ticks through the plain banking and
// protected modes under several register settings, predicts every result
// and checks each popped result against the oldest prediction.
// ----------------------------------------------------------------------------
module banked_memory_map_with_protection_test;
   import bmm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 10;

   typedef struct packed {
      op_type      op;
      logic [15:0] addr;
      logic [7:0]  val;
      logic        dbg;
   } bus_access_type;

   class map_scoreboard;
      logic        protected_card;
      logic [7:0]  io_page;
      logic [16:0] wd_limit;
      logic [5:0]  bank_pages [4];
      logic        banking_on;
      logic [7:0]  mmu_value;
      logic        supervisor;
      logic [16:0] wd_count;
      rsp_type     pending_routes [$];
      int          errors;

      function new();
         protected_card = 1'b0;
         io_page        = IO_PAGE_RESET;
         wd_limit       = WD_LIMIT_RESET;
         foreach (bank_pages[i]) bank_pages[i] = '0;
         banking_on     = 1'b0;
         mmu_value      = '0;
         supervisor     = 1'b1;
         wd_count       = '0;
         errors         = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [CSR_WIDTH-1:0] v);
         case (idx)
            CSR_PROTECTED: protected_card = v[0];
            CSR_IO_PAGE:   io_page = v[7:0];
            CSR_WD_LIMIT:  wd_limit = v[16:0];
            default: ;
         endcase
      endfunction

      function logic [3:0] region_of(logic [15:0] addr);
         logic [7:0] r;
         r = mmu_value;
         if (addr < HIGH_BASE) r = r >> 1;
         return {r[0], r[2], r[4], r[6]};
      endfunction

      function void note_access(bus_access_type a);
         rsp_type    e;
         logic       io_hit;
         logic [3:0] rg;
         logic [5:0] pg;
         logic [7:0] off;
         e = '0;
         e.route = RT_TICK;
         io_hit = (a.addr[15:8] == io_page) && supervisor;
         off = a.addr[7:0];
         case (a.op)
            OP_TICK: begin
               if (protected_card) begin
                  if (!supervisor) begin
                     if (wd_count != WD_MAX) begin
                        wd_count = wd_count + 17'd1;
                        if (wd_count == wd_limit) e.nmi = 1'b1;
                     end
                  end else begin
                     wd_count = '0;
                  end
               end
            end
            OP_READ: begin
               if (io_hit) begin
                  e.ioff = off;
                  if (a.dbg) begin
                     e.route = RT_DBG_RD;
                     e.dout = DEBUG_BYTE;
                  end else begin
                     e.route = RT_IO_RD;
                  end
               end else begin
                  e.route = RT_MEM_RD;
                  if (protected_card) begin
                     if (a.addr >= VECTOR_BASE) begin
                        mmu_value = VECTOR_MMU;
                        supervisor = 1'b1;
                     end
                     e.phys = {region_of(a.addr), a.addr};
                  end else if (banking_on) begin
                     e.phys = {bank_pages[a.addr[15:14]], a.addr[13:0]};
                  end else begin
                     e.phys = {6'd0, a.addr[13:0]};
                  end
               end
            end
            OP_WRITE: begin
               e.dout = a.val;
               if (io_hit) begin
                  e.ioff = off;
                  e.route = RT_IO_WR;
                  if (!protected_card && off >= BANK_FIRST && off <= BANK_LAST) begin
                     bank_pages[off[1:0]] = a.val[5:0];
                     e.route = RT_REG_WR;
                  end else if (!protected_card && off >= ENABLE_FIRST && off <= ENABLE_LAST) begin
                     banking_on = a.val[0];
                     e.route = RT_REG_WR;
                  end else if (protected_card && off == MMU_OFFSET) begin
                     mmu_value = a.val;
                     supervisor = 1'b0;
                     e.route = RT_REG_WR;
                  end
               end else if (protected_card) begin
                  rg = region_of(a.addr);
                  e.phys = {rg, a.addr};
                  e.route = rg[3] ? RT_MEM_WR : RT_ROM_WR;
               end else if (banking_on) begin
                  pg = bank_pages[a.addr[15:14]];
                  e.phys = {pg, a.addr[13:0]};
                  e.route = (pg >= ROM_PAGES) ? RT_MEM_WR : RT_ROM_WR;
               end else begin
                  e.phys = {6'd0, a.addr[13:0]};
                  e.route = RT_ROM_WR;
               end
            end
            default: ;
         endcase
         e.kernel = supervisor;
         pending_routes.push_back(e);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned seen);
         if (want != seen) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, seen);
         end
      endfunction

      function void check_route(rsp_type got);
         rsp_type e;
         if (pending_routes.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual route %0d phys %0h",
                     $time, got.route, got.phys);
            return;
         end
         e = pending_routes.pop_front();
         compare_field("route", e.route, got.route);
         compare_field("physical_address", e.phys, got.phys);
         compare_field("io_offset", e.ioff, got.ioff);
         compare_field("data_out", e.dout, got.dout);
         compare_field("nmi_pulse", e.nmi, got.nmi);
         compare_field("kernel_mode", e.kernel, got.kernel);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;
   logic                 push = 1'b0;
   logic                 full;
   logic [1:0]           req_operation = '0;
   logic [15:0]          req_cpu_address = '0;
   logic [7:0]           req_write_value = '0;
   logic                 req_debug_access = 1'b0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [2:0]           rsp_route;
   logic [19:0]          rsp_physical_address;
   logic [7:0]           rsp_io_offset;
   logic [7:0]           rsp_data_out;
   logic                 rsp_nmi_pulse;
   logic                 rsp_kernel_mode;

   map_scoreboard sb;
   int            sent_count = 0;
   int            send_idle_pct = 16;
   int            take_idle_pct = 52;
   int            cycle_count = 0;

   banked_memory_map_with_protection dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .push(push),
      .full(full),
      .req_operation(req_operation),
      .req_cpu_address(req_cpu_address),
      .req_write_value(req_write_value),
      .req_debug_access(req_debug_access),
      .empty(empty),
      .pop(pop),
      .rsp_route(rsp_route),
      .rsp_physical_address(rsp_physical_address),
      .rsp_io_offset(rsp_io_offset),
      .rsp_data_out(rsp_data_out),
      .rsp_nmi_pulse(rsp_nmi_pulse),
      .rsp_kernel_mode(rsp_kernel_mode)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      rsp_type got;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            got.route  = route_type'(rsp_route);
            got.phys   = rsp_physical_address;
            got.ioff   = rsp_io_offset;
            got.dout   = rsp_data_out;
            got.nmi    = rsp_nmi_pulse;
            got.kernel = rsp_kernel_mode;
            sb.check_route(got);
         end
         pop <= !reset && ($urandom_range(99) >= take_idle_pct);
      end
   end

   function automatic bus_access_type access(op_type op, logic [15:0] addr,
                                             logic [7:0] val, logic dbg);
      bus_access_type a;
      a.op = op;
      a.addr = addr;
      a.val = val;
      a.dbg = dbg;
      return a;
   endfunction

   function automatic logic [15:0] any_address();
      logic [15:0] corners [8];
      corners = '{16'h0000, 16'hFFFF, 16'hDFFF, 16'hE000,
                  16'h3FFF, 16'h4000, 16'hBFFF, 16'hC000};
      if ($urandom_range(3) == 0) return corners[$urandom_range(7)];
      return 16'($urandom);
   endfunction

   function automatic bus_access_type random_access();
      bus_access_type a;
      int             pick;
      a.op   = $urandom_range(1) ? OP_WRITE : OP_READ;
      a.addr = any_address();
      a.val  = 8'($urandom);
      a.dbg  = 1'($urandom_range(1));
      pick   = $urandom_range(99);
      if (sb.protected_card && sb.supervisor) begin
         if (pick < 30) begin
            a.op = OP_WRITE;
            a.addr = {sb.io_page, MMU_OFFSET};
         end else if (pick < 42) begin
            a.addr[15:8] = sb.io_page;
         end else if (pick < 52) begin
            a.op = OP_TICK;
         end else if (pick < 56) begin
            a.op = OP_READ;
            a.addr = VECTOR_BASE | 16'($urandom_range(15));
         end else if (pick < 58) begin
            a.op = OP_NONE;
         end
      end else if (sb.protected_card) begin
         if (pick < 35) begin
            a.op = OP_TICK;
         end else if (pick < 39) begin
            a.op = OP_READ;
            a.addr = VECTOR_BASE | 16'($urandom_range(15));
         end else if (pick < 41) begin
            a.op = OP_NONE;
         end else if (pick < 48) begin
            a.addr[15:8] = sb.io_page;
         end
      end else begin
         if (pick < 25) begin
            a.op = OP_WRITE;
            a.addr = {sb.io_page, BANK_FIRST | 8'($urandom_range(7))};
         end else if (pick < 37) begin
            a.addr[15:8] = sb.io_page;
         end else if (pick < 44) begin
            a.op = OP_TICK;
         end else if (pick < 47) begin
            a.op = OP_NONE;
         end
      end
      return a;
   endfunction

   task automatic send_access(bus_access_type a);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_operation <= a.op;
      req_cpu_address <= a.addr;
      req_write_value <= a.val;
      req_debug_access <= a.dbg;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_access(a);
      sent_count++;
      if (sent_count < 480) begin
         send_idle_pct = 16;
         take_idle_pct = 52;
      end else if (sent_count < 960) begin
         send_idle_pct = 52;
         take_idle_pct = 16;
      end else begin
         send_idle_pct = 0;
         take_idle_pct = 0;
      end
   endtask

   task automatic drain_results();
      push <= 1'b0;
      while (sb.pending_routes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_map(logic prot, logic [7:0] page, logic [16:0] limit);
      logic [CSR_WIDTH-1:0] v [3];
      logic [1:0]           idx [3];
      idx = '{CSR_PROTECTED, CSR_IO_PAGE, CSR_WD_LIMIT};
      v[0] = {16'($urandom), prot};
      v[1] = {9'($urandom), page};
      v[2] = limit;
      csr_we <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index <= idx[i];
         csr_wdata <= v[i];
         @(posedge clock);
         sb.set_register(idx[i], v[i]);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      logic        ph_prot [PHASES];
      logic [7:0]  ph_page [PHASES];
      logic [16:0] ph_limit [PHASES];
      int          ph_items [PHASES];
      logic [7:0]  page;
      logic [16:0] limit;
      ph_prot  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      ph_page  = '{8'hFE, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFE, 8'h3C, 8'h00, 8'h00};
      ph_limit = '{17'd2, 17'd65536, 17'd1, 17'h1FFFF, 17'd7,
                   17'd12, 17'd1, 17'd5, 17'd3, 17'd3};
      ph_items = '{140, 150, 150, 100, 150, 200, 150, 200, 100, 110};
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_access(access(OP_READ,  16'h0000, 8'h00, 1'b0));
      send_access(access(OP_READ,  16'hFFFF, 8'hFF, 1'b1));
      send_access(access(OP_WRITE, 16'h8000, 8'hAA, 1'b0));
      send_access(access(OP_READ,  16'hFE10, 8'h00, 1'b0));
      send_access(access(OP_READ,  16'hFE10, 8'h00, 1'b1));
      send_access(access(OP_WRITE, 16'hFE00, 8'h55, 1'b0));
      send_access(access(OP_WRITE, 16'hFE78, 8'hFF, 1'b0));
      send_access(access(OP_WRITE, 16'hFE79, 8'h00, 1'b0));
      send_access(access(OP_WRITE, 16'hFE7A, 8'h20, 1'b0));
      send_access(access(OP_WRITE, 16'hFE7B, 8'h1F, 1'b0));
      send_access(access(OP_WRITE, 16'hFE7C, 8'h01, 1'b0));
      send_access(access(OP_WRITE, 16'h0000, 8'hFF, 1'b0));
      send_access(access(OP_WRITE, 16'h4000, 8'h00, 1'b0));
      send_access(access(OP_WRITE, 16'h8123, 8'h3C, 1'b0));
      send_access(access(OP_WRITE, 16'hFFFF, 8'hC3, 1'b0));
      send_access(access(OP_READ,  16'hC000, 8'h00, 1'b1));
      send_access(access(OP_TICK,  16'h0000, 8'h00, 1'b0));
      send_access(access(OP_NONE,  16'hFFFF, 8'hFF, 1'b1));
      send_access(access(OP_WRITE, 16'hFE7F, 8'hFE, 1'b0));
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         page = ph_page[p];
         limit = ph_limit[p];
         if (p >= 8) begin
            page = 8'($urandom);
            limit = 17'($urandom_range(20, 1));
         end
         program_map(ph_prot[p], page, limit);
         if (p == 0) begin
            send_access(access(OP_WRITE, 16'hFEFF, 8'h55, 1'b0));
            send_access(access(OP_WRITE, 16'h1234, 8'h00, 1'b0));
            send_access(access(OP_WRITE, 16'hE000, 8'hFF, 1'b0));
            send_access(access(OP_TICK,  16'h0000, 8'h00, 1'b0));
            send_access(access(OP_TICK,  16'h0000, 8'h00, 1'b0));
            send_access(access(OP_READ,  16'hFFF0, 8'h00, 1'b1));
            send_access(access(OP_TICK,  16'h0000, 8'h00, 1'b0));
         end
         for (int i = 0; i < ph_items[p]; i++) send_access(random_access());
         // One protected phase is left in user mode so that the next plain
         // phase runs with the supervisor flag clear.
         if (ph_prot[p] && p != 5)
            send_access(access(OP_READ, VECTOR_BASE, 8'h00, 1'b0));
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending_routes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bmm_pkg.sv
rtl/bmm_front.sv
rtl/bmm_back.sv
rtl/banked_memory_map_with_protection.sv
dv/banked_memory_map_with_protection_test.sv
